// ----- rtl/gms_pkg.sv -----
// Package for the grid maze router: request and response types, codes and
// shared constants. No dependencies.
package gms_pkg;

    // Width of a clamped grid dimension (covers up to 256 rows or columns).
    localparam int DIM_W = 9;
    localparam int LEN_W = 13;
    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 64;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SOLVE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] MARK_BLANK  = 2'd0;
    localparam logic [1:0] MARK_START  = 2'd1;
    localparam logic [1:0] MARK_PATH   = 2'd2;
    localparam logic [1:0] MARK_FINISH = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNREACH = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] cell_kind;
    } t_req;

    typedef struct packed {
        logic [12:0] path_length;
        logic [1:0]  cell_mark;
        logic [1:0]  status;
    } t_rsp;

    // Decoded request handed from the top level to the engine.
    typedef struct packed {
        logic       go;
        logic [1:0] mode;
        logic       stored;
        logic [1:0] kind;
    } t_cmd;

    // Endpoint status seen by the engine at solve time.
    typedef struct packed {
        logic start_ok;
        logic fin_ok;
    } t_ends;

endpackage

// ----- rtl/gms_nbr.sv -----
// Neighbor unit: steps one cell up, down, left or right inside the active area.
// Depends on gms_pkg.
module gms_nbr
    import gms_pkg::*;
#(
    parameter int MAX_ROWS = DEF_ROWS,
    parameter int MAX_COLS = DEF_COLS
) (
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_cur,
    input  logic [1:0]                                   i_dir,
    input  logic [DIM_W-1:0]                             i_nr,
    input  logic [DIM_W-1:0]                             i_nc,
    output logic                                         o_valid,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] o_nb
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    logic [DIM_W-1:0] w_r;
    logic [DIM_W-1:0] w_c;
    logic [DIM_W-1:0] w_nr_row;
    logic [DIM_W-1:0] w_nr_col;

    // Move one step and check against the border and the active area.
    always_comb begin
        w_r = DIM_W'(i_cur[RW+CW-1:CW]);
        w_c = DIM_W'(i_cur[CW-1:0]);
        w_nr_row = w_r;
        w_nr_col = w_c;
        o_valid = 1'b1;
        case (i_dir)
            DIR_UP: begin
                if (w_r == '0) o_valid = 1'b0;
                w_nr_row = w_r - DIM_W'(1);
            end
            DIR_DOWN: begin
                w_nr_row = w_r + DIM_W'(1);
            end
            DIR_LEFT: begin
                if (w_c == '0) o_valid = 1'b0;
                w_nr_col = w_c - DIM_W'(1);
            end
            default: begin
                w_nr_col = w_c + DIM_W'(1);
            end
        endcase
        if (w_nr_row >= i_nr || w_nr_col >= i_nc) o_valid = 1'b0;
        o_nb = {w_nr_row[RW-1:0], w_nr_col[CW-1:0]};
    end
endmodule

// ----- rtl/gms_engine.sv -----
// Sequencer and cell memories of the maze router: clear sweep, breadth-first
// labelling, path trace and cell access. Depends on gms_pkg and gms_nbr.
module gms_engine
    import gms_pkg::*;
#(
    parameter int MAX_ROWS = DEF_ROWS,
    parameter int MAX_COLS = DEF_COLS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  t_cmd                                         i_cmd,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_addr,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_start_pos,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_fin_pos,
    input  t_ends                                        i_ends,
    input  logic [DIM_W-1:0]                             i_nr,
    input  logic [DIM_W-1:0]                             i_nc,
    output logic                                         o_busy,
    output logic                                         o_done,
    output t_rsp                                         o_rsp
);
    localparam int AW    = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int LW    = CNTW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_BTEST  = 4'd3;
    localparam logic [3:0] S_BCUR   = 4'd4;
    localparam logic [3:0] S_BLAB   = 4'd5;
    localparam logic [3:0] S_BNRD   = 4'd6;
    localparam logic [3:0] S_BNEV   = 4'd7;
    localparam logic [3:0] S_TINIT  = 4'd8;
    localparam logic [3:0] S_TLAB   = 4'd9;
    localparam logic [3:0] S_TNRD   = 4'd10;
    localparam logic [3:0] S_TNEV   = 4'd11;
    localparam logic [3:0] S_TSTART = 4'd12;
    localparam logic [3:0] S_TFIN   = 4'd13;
    localparam logic [3:0] S_RDOUT  = 4'd14;

    // Cell memories.
    logic [1:0]    kind_mem  [DEPTH];
    logic [1:0]    mark_mem  [DEPTH];
    logic [LW-1:0] label_mem [DEPTH];
    logic [AW-1:0] queue_mem [DEPTH];

    logic [3:0]      r_state,   n_state;
    logic            r_clr_kind, n_clr_kind;
    logic [AW-1:0]   r_sweep,   n_sweep;
    logic [CNTW-1:0] r_head,    n_head;
    logic [CNTW-1:0] r_tail,    n_tail;
    logic [AW-1:0]   r_cur,     n_cur;
    logic [AW-1:0]   r_nb,      n_nb;
    logic [LW-1:0]   r_cur_lab, n_cur_lab;
    logic [1:0]      r_dir,     n_dir;
    logic [CNTW-1:0] r_steps,   n_steps;
    logic            r_hit,     n_hit;
    logic [LW-1:0]   r_found,   n_found;
    logic            r_stored,  n_stored;
    logic            r_done,    n_done;
    t_rsp            r_rsp,     n_rsp;

    logic          kind_we,  mark_we,  label_we,  queue_we;
    logic [AW-1:0] kind_wa,  mark_wa,  label_wa,  queue_wa;
    logic [1:0]    kind_wd,  mark_wd;
    logic [LW-1:0] label_wd;
    logic [AW-1:0] queue_wd;
    logic [AW-1:0] kind_ra,  mark_ra,  label_ra,  queue_ra;
    logic [1:0]    kind_rd,  mark_rd;
    logic [LW-1:0] label_rd;
    logic [AW-1:0] queue_rd;

    logic          w_nb_valid;
    logic [AW-1:0] w_nb;

    gms_nbr #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_nbr (
        .i_cur   (r_cur),
        .i_dir   (r_dir),
        .i_nr    (i_nr),
        .i_nc    (i_nc),
        .o_valid (w_nb_valid),
        .o_nb    (w_nb)
    );

    // Memory ports: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (kind_we) kind_mem[kind_wa] <= kind_wd;
        kind_rd <= kind_mem[kind_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) mark_mem[mark_wa] <= mark_wd;
        mark_rd <= mark_mem[mark_ra];
    end

    always_ff @(posedge i_clk) begin
        if (label_we) label_mem[label_wa] <= label_wd;
        label_rd <= label_mem[label_ra];
    end

    always_ff @(posedge i_clk) begin
        if (queue_we) queue_mem[queue_wa] <= queue_wd;
        queue_rd <= queue_mem[queue_ra];
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_clr_kind = r_clr_kind;
        n_sweep    = r_sweep;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_nb       = r_nb;
        n_cur_lab  = r_cur_lab;
        n_dir      = r_dir;
        n_steps    = r_steps;
        n_hit      = r_hit;
        n_found    = r_found;
        n_stored   = r_stored;
        n_done     = 1'b0;
        n_rsp      = '0;

        kind_we  = 1'b0; kind_wa  = r_sweep; kind_wd  = KIND_FREE;
        mark_we  = 1'b0; mark_wa  = r_sweep; mark_wd  = MARK_BLANK;
        label_we = 1'b0; label_wa = r_sweep; label_wd = '0;
        queue_we = 1'b0; queue_wa = r_tail[AW-1:0]; queue_wd = r_nb;
        kind_ra  = w_nb;
        mark_ra  = i_addr;
        label_ra = w_nb;
        queue_ra = r_head[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd.go) begin
                    case (i_cmd.mode)
                        MODE_LOAD: begin
                            kind_we = i_cmd.stored;
                            kind_wa = i_addr;
                            kind_wd = i_cmd.kind;
                            n_done  = 1'b1;
                        end
                        MODE_SOLVE: begin
                            n_state    = S_CLR;
                            n_clr_kind = 1'b0;
                            n_sweep    = '0;
                        end
                        MODE_READ: begin
                            n_stored = i_cmd.stored;
                            n_state  = S_RDOUT;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                n_rsp.path_length = LEN_W'(r_found);
                n_rsp.cell_mark   = r_stored ? mark_rd : MARK_BLANK;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            // Clear labels and marks (and the cell kinds after reset).
            S_CLR: begin
                label_we = 1'b1;
                mark_we  = 1'b1;
                kind_we  = r_clr_kind;
                n_sweep  = r_sweep + AW'(1);
                if (&r_sweep) begin
                    n_clr_kind = 1'b0;
                    n_state    = r_clr_kind ? S_IDLE : S_CHK;
                end
            end
            S_CHK: begin
                n_found = '0;
                if (!(i_ends.start_ok && i_ends.fin_ok)) begin
                    n_rsp.status = STAT_MISSING;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    label_we = 1'b1;
                    label_wa = i_start_pos;
                    label_wd = LW'(1);
                    queue_we = 1'b1;
                    queue_wa = '0;
                    queue_wd = i_start_pos;
                    n_head   = '0;
                    n_tail   = CNTW'(1);
                    n_hit    = (i_start_pos == i_fin_pos);
                    n_state  = S_BTEST;
                end
            end
            // Pop the next frontier cell unless the finish is labelled or the queue is empty.
            S_BTEST: begin
                if (r_hit) begin
                    n_state = S_TINIT;
                end else if (r_head == r_tail) begin
                    n_rsp.status = STAT_UNREACH;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_head  = r_head + CNTW'(1);
                    n_state = S_BCUR;
                end
            end
            S_BCUR: begin
                n_cur    = queue_rd;
                label_ra = queue_rd;
                n_state  = S_BLAB;
            end
            S_BLAB: begin
                n_cur_lab = label_rd;
                n_dir     = DIR_UP;
                n_state   = S_BNRD;
            end
            S_BNRD: begin
                if (w_nb_valid) begin
                    n_nb    = w_nb;
                    n_state = S_BNEV;
                end else if (r_dir == DIR_RIGHT) begin
                    n_state = S_BTEST;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            // Label an unvisited open neighbor and queue it.
            S_BNEV: begin
                if (kind_rd != KIND_WALL && label_rd == '0) begin
                    label_we = 1'b1;
                    label_wa = r_nb;
                    label_wd = r_cur_lab + LW'(1);
                    if (r_tail < CNTW'(CELLS)) begin
                        queue_we = 1'b1;
                        n_tail   = r_tail + CNTW'(1);
                    end
                    if (r_nb == i_fin_pos) n_hit = 1'b1;
                end
                if (r_dir == DIR_RIGHT) begin
                    n_state = S_BTEST;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_BNRD;
                end
            end
            S_TINIT: begin
                label_ra = i_fin_pos;
                n_cur    = i_fin_pos;
                n_state  = S_TLAB;
            end
            S_TLAB: begin
                n_cur_lab = label_rd;
                n_found   = label_rd;
                n_dir     = DIR_UP;
                n_steps   = '0;
                n_state   = S_TNRD;
            end
            // Walk back toward the start one cell at a time.
            S_TNRD: begin
                if (r_cur == i_start_pos || r_steps == CNTW'(CELLS)) begin
                    n_state = S_TSTART;
                end else if (w_nb_valid) begin
                    n_nb    = w_nb;
                    n_state = S_TNEV;
                end else if (r_dir == DIR_RIGHT) begin
                    n_state = S_TSTART;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            S_TNEV: begin
                if (label_rd != '0 &&
                    ((LW+1)'(label_rd) + (LW+1)'(1)) == (LW+1)'(r_cur_lab)) begin
                    mark_we   = 1'b1;
                    mark_wa   = r_cur;
                    mark_wd   = MARK_PATH;
                    n_cur     = r_nb;
                    n_cur_lab = label_rd;
                    n_steps   = r_steps + CNTW'(1);
                    n_dir     = DIR_UP;
                    n_state   = S_TNRD;
                end else if (r_dir == DIR_RIGHT) begin
                    n_state = S_TSTART;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_TNRD;
                end
            end
            S_TSTART: begin
                mark_we = 1'b1;
                mark_wa = i_start_pos;
                mark_wd = MARK_START;
                n_state = S_TFIN;
            end
            S_TFIN: begin
                mark_we = 1'b1;
                mark_wa = i_fin_pos;
                mark_wd = MARK_FINISH;
                n_rsp.path_length = LEN_W'(r_found);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_kind <= 1'b1;
            r_sweep    <= '0;
            r_found    <= '0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_kind <= n_clr_kind;
            r_sweep    <= n_sweep;
            r_found    <= n_found;
            r_done     <= n_done;
            r_hit      <= n_hit;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_tail    <= n_tail;
        r_cur     <= n_cur;
        r_nb      <= n_nb;
        r_cur_lab <= n_cur_lab;
        r_dir     <= n_dir;
        r_steps   <= n_steps;
        r_stored  <= n_stored;
        r_rsp     <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule

// ----- rtl/grid_maze_shortest_path.sv -----
// Top level of the grid maze router: configuration registers, start and finish
// tracking and the request port. Depends on gms_pkg and gms_engine.
//
//   channel   ports                             handshake
//   request   start, busy, i_req                taken when start & !busy
//   result    o_done, o_rsp                     one-cycle strobe, no stall
//   config    i_cfg_we, i_cfg_idx, i_cfg_data   taken when i_cfg_we
//
// After reset the block clears its cell memories, one cell a cycle, over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096 by default) with busy high.
// A load or an unused mode gives its result on the next cycle; a read passes
// through the read-out state first. A solve runs a clear sweep of labels and
// marks, then labels the grid breadth-first from the queue, one neighbor at a
// time, then traces the path back cell by cell, with one shared neighbor unit.
// The receiver cannot stall results.
module grid_maze_shortest_path
    import gms_pkg::*;
#(
    parameter int MAX_ROWS = DEF_ROWS,
    parameter int MAX_COLS = DEF_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;

    logic [6:0]       r_rows_used;
    logic [6:0]       r_cols_used;
    logic [AW-1:0]    r_start_pos;
    logic [AW-1:0]    r_fin_pos;
    logic             r_start_valid;
    logic             r_fin_valid;

    logic [DIM_W-1:0] w_nr;
    logic [DIM_W-1:0] w_nc;
    logic [DIM_W-1:0] w_row;
    logic [DIM_W-1:0] w_col;
    logic [AW-1:0]    w_addr;
    logic             w_stored;
    logic             w_go;
    t_cmd             w_cmd;
    t_ends            w_ends;

    // Clamp the configured dimensions into the stored grid.
    always_comb begin
        w_nr = DIM_W'(r_rows_used);
        w_nc = DIM_W'(r_cols_used);
        if (w_nr == '0) w_nr = DIM_W'(1);
        else if (w_nr > DIM_W'(MAX_ROWS)) w_nr = DIM_W'(MAX_ROWS);
        if (w_nc == '0) w_nc = DIM_W'(1);
        else if (w_nc > DIM_W'(MAX_COLS)) w_nc = DIM_W'(MAX_COLS);
    end

    // Decode the request.
    always_comb begin
        w_row    = DIM_W'(i_req.row);
        w_col    = DIM_W'(i_req.col);
        w_stored = (w_row < DIM_W'(MAX_ROWS)) && (w_col < DIM_W'(MAX_COLS));
        w_addr   = {w_row[RW-1:0], w_col[CW-1:0]};
        w_go     = start && !busy;
        w_cmd.go     = w_go;
        w_cmd.mode   = i_req.mode;
        w_cmd.stored = w_stored;
        w_cmd.kind   = i_req.cell_kind;
    end

    // An endpoint counts only when loaded and inside the active area.
    always_comb begin
        w_ends.start_ok = r_start_valid &&
                          (DIM_W'(r_start_pos[AW-1:CW]) < w_nr) &&
                          (DIM_W'(r_start_pos[CW-1:0]) < w_nc);
        w_ends.fin_ok   = r_fin_valid &&
                          (DIM_W'(r_fin_pos[AW-1:CW]) < w_nr) &&
                          (DIM_W'(r_fin_pos[CW-1:0]) < w_nc);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= 7'(DEF_ROWS);
            r_cols_used <= 7'(DEF_COLS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows_used <= i_cfg_data;
                CFG_COLS: r_cols_used <= i_cfg_data;
                default:  r_rows_used <= r_rows_used;
            endcase
        end
    end

    // Start and finish tracking on loads; the last one loaded wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos   <= '0;
            r_fin_pos     <= '0;
            r_start_valid <= 1'b0;
            r_fin_valid   <= 1'b0;
        end else if (w_go && i_req.mode == MODE_LOAD && w_stored) begin
            if (i_req.cell_kind == KIND_START) begin
                r_start_pos   <= w_addr;
                r_start_valid <= 1'b1;
            end else if (r_start_pos == w_addr) begin
                r_start_valid <= 1'b0;
            end
            if (i_req.cell_kind == KIND_FINISH) begin
                r_fin_pos   <= w_addr;
                r_fin_valid <= 1'b1;
            end else if (r_fin_pos == w_addr) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    gms_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_addr      (w_addr),
        .i_start_pos (r_start_pos),
        .i_fin_pos   (r_fin_pos),
        .i_ends      (w_ends),
        .i_nr        (w_nr),
        .i_nc        (w_nc),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // A result is only shown once the engine is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // A load request answers on the next cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.mode == MODE_LOAD) |=> o_done)
        else $error("load result missing");

    // A read request answers once the read-out state has registered its result.
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.mode == MODE_READ) |=> ##1 o_done)
        else $error("read result missing");

    // Reset starts the memory clear sweep.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clear sweep after reset");
`endif
endmodule
